// ===== rtl/core/rrb_pkg.sv =====
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types and constants of the receive reassembly buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrb_pkg;

    // width of the contiguous-count result field
    localparam int AVAIL_W = 13;

    // one classified input item, as queued between front and back
    typedef struct packed {
        logic        kind;            // 0 = segment byte, 1 = read
        logic [31:0] seg_start;
        logic [15:0] seg_length;
        logic [15:0] byte_offset;
        logic [7:0]  data_byte;
        logic        last_of_segment;
        logic        in_range;        // byte_offset below seg_length
    } t_item;

    // result fields except the contiguous count
    typedef struct packed {
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        ack_now;
        logic        reject_now;
        logic [31:0] ack_seq;
        logic [15:0] echo_len;
    } t_result;

    // item kinds
    localparam logic KIND_SEG  = 1'b0;
    localparam logic KIND_READ = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/receive_reassembly_buffer.sv =====
// ----------------------------------------------------------------------------
// receive_reassembly_buffer
// Receive side of one byte-stream connection: segment bytes are placed in a
// ring by stream offset, reads take bytes from the head while they are there.
// ----------------------------------------------------------------------------
//   channel  | valid    | stall    | payload
//   ---------+----------+----------+--------------------------------------------
//   input    | i_valid  | o_stall  | i_kind .. i_last_of_segment
//   result   | o_valid  | i_stall  | o_read_valid .. o_available
//
// After reset a clearing pass runs over every entry of the mark memory; items
// queue in the front but are not executed until it ends.
// A segment byte that grows the contiguous count walks the mark memory entry by
// entry, through a read and a check state each, before done. A read of a present
// head byte waits on the byte memory before done; a read of an absent one does not.
// A two-entry queue decouples input from execution; the result register holds
// under i_stall while the next item is already taken.
// DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module receive_reassembly_buffer #(
    parameter int DEPTH = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic          i_kind,
    input  wire logic [31:0]   i_seg_start,
    input  wire logic [15:0]   i_seg_length,
    input  wire logic [15:0]   i_byte_offset,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_of_segment,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic               o_read_valid,
    output logic [7:0]         o_read_byte,
    output logic               o_ack_now,
    output logic               o_reject_now,
    output logic [31:0]        o_ack_seq,
    output logic [15:0]        o_echo_len,
    output logic [rrb_pkg::AVAIL_W-1:0] o_available
);
    import rrb_pkg::*;

    t_item   item;
    logic    item_valid;
    logic    pop;
    t_result res;

    rrb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_seg_start       (i_seg_start),
        .i_seg_length      (i_seg_length),
        .i_byte_offset     (i_byte_offset),
        .i_data_byte       (i_data_byte),
        .i_last_of_segment (i_last_of_segment),
        .o_item            (item),
        .o_item_valid      (item_valid),
        .i_pop             (pop)
    );

    rrb_back #(.DEPTH(DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (res),
        .o_available  (o_available)
    );

    assign o_read_valid = res.read_valid;
    assign o_read_byte  = res.read_byte;
    assign o_ack_now    = res.ack_now;
    assign o_reject_now = res.reject_now;
    assign o_ack_seq    = res.ack_seq;
    assign o_echo_len   = res.echo_len;

endmodule

`default_nettype wire

// ===== rtl/core/rrb_ram.sv =====
// ----------------------------------------------------------------------------
// rrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/rrb_front.sv =====
// ----------------------------------------------------------------------------
// rrb_front
// Input side: takes items, flags out-of-segment bytes, queues two items.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic          i_kind,
    input  wire logic [31:0]   i_seg_start,
    input  wire logic [15:0]   i_seg_length,
    input  wire logic [15:0]   i_byte_offset,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_of_segment,
    output rrb_pkg::t_item     o_item,
    output logic               o_item_valid,
    input  wire logic          i_pop
);
    import rrb_pkg::*;

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       n_entry;
    logic        push;

    // classify the incoming item
    always_comb begin
        n_entry.kind            = i_kind;
        n_entry.seg_start       = i_seg_start;
        n_entry.seg_length      = i_seg_length;
        n_entry.byte_offset     = i_byte_offset;
        n_entry.data_byte       = i_data_byte;
        n_entry.last_of_segment = i_last_of_segment;
        n_entry.in_range        = (i_byte_offset < i_seg_length);
    end

    assign o_stall      = (r_cnt == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_entry;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rrb_back.sv =====
// ----------------------------------------------------------------------------
// rrb_back
// Execution side: ring store, mark memory, head tracking, contiguous count
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrb_back #(
    parameter int DEPTH = 4096
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire rrb_pkg::t_item          i_item,
    input  wire logic                    i_item_valid,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output rrb_pkg::t_result             o_result,
    output logic [rrb_pkg::AVAIL_W-1:0]  o_available
);
    import rrb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = ((AW > 16) ? AW : 16) + 1;
    localparam logic [AW-1:0] AMAX = {AW{1'b1}};
    localparam logic [AW-1:0] AONE = AW'(1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RDW  = 3'd2;
    localparam logic [2:0] S_SCR  = 3'd3;
    localparam logic [2:0] S_SCC  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    r_state;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_head;
    logic [31:0]   r_shead;
    logic [AW-1:0] r_n;
    t_result       r_res;
    logic          r_ovalid;
    t_result       r_out;
    logic [AVAIL_W-1:0] r_avail;

    logic [31:0]   seg_dist;
    logic          ok;
    logic [AW-1:0] k;
    logic [AW-1:0] slot;
    logic          store, rd_hit, out_free, emit;
    logic          m_we, m_wdata, m_rdata;
    logic [AW-1:0] m_waddr;
    logic [7:0]    b_rdata;

    // acceptance window and ring slot
    assign seg_dist = i_item.seg_start - r_shead;
    assign ok   = (seg_dist < 32'(DEPTH)) &&
                  ((SW'(seg_dist[AW-1:0]) + SW'(i_item.seg_length)) < SW'(DEPTH));
    assign k    = seg_dist[AW-1:0] + AW'(i_item.byte_offset);
    assign slot = r_head + k;

    assign o_pop    = (r_state == S_IDLE) && i_item_valid;
    assign store    = o_pop && (i_item.kind == KIND_SEG) && ok && i_item.in_range;
    assign rd_hit   = o_pop && (i_item.kind == KIND_READ) && (r_n != '0);
    assign out_free = !r_ovalid || !i_stall;
    assign emit     = (r_state == S_DONE) && out_free;

    // mark memory write port: clearing pass, set on store, clear on read
    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_head;
        m_wdata = 1'b0;
        priority if (r_state == S_CLR) begin
            m_we    = 1'b1;
            m_waddr = r_clr;
        end else if (store) begin
            m_we    = 1'b1;
            m_waddr = slot;
            m_wdata = 1'b1;
        end else if (rd_hit) begin
            m_we    = 1'b1;
        end
    end

    rrb_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (r_head + r_n),
        .o_rdata (m_rdata)
    );

    rrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bytes (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (slot),
        .i_wdata (i_item.data_byte),
        .i_raddr (r_head),
        .o_rdata (b_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_head  <= '0;
            r_shead <= '0;
            r_n     <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AONE;
                    if (r_clr == AMAX) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_pop) begin
                        if (rd_hit) begin
                            r_head  <= r_head + AONE;
                            r_shead <= r_shead + 32'd1;
                            r_n     <= r_n - AONE;
                            r_state <= S_RDW;
                        end else if (store && (k == r_n)) begin
                            r_n     <= r_n + AONE;
                            r_state <= S_SCR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RDW: r_state <= S_DONE;
                S_SCR: r_state <= S_SCC;
                S_SCC: begin
                    // extend over marks that were already in place
                    if (m_rdata && (r_n != AMAX)) begin
                        r_n     <= r_n + AONE;
                        r_state <= S_SCR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.read_valid <= rd_hit;
            r_res.read_byte  <= 8'd0;
            r_res.ack_now    <= (i_item.kind == KIND_SEG) && i_item.last_of_segment && ok;
            r_res.reject_now <= (i_item.kind == KIND_SEG) && i_item.last_of_segment && !ok;
            if ((i_item.kind == KIND_SEG) && i_item.last_of_segment) begin
                r_res.ack_seq  <= i_item.seg_start;
                r_res.echo_len <= i_item.seg_length;
            end else begin
                r_res.ack_seq  <= 32'd0;
                r_res.echo_len <= 16'd0;
            end
        end else if (r_state == S_RDW) begin
            r_res.read_byte <= b_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out   <= r_res;
            r_avail <= AVAIL_W'(r_n);
        end
    end

    assign o_valid     = r_ovalid;
    assign o_result    = r_out;
    assign o_available = r_avail;

    // items are only taken while the sequencer is free
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("item taken while busy");

    // a successful read shrinks the count by one
    a_read_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_hit |=> (r_n == $past(r_n) - AONE))
        else $error("count not decremented on read");

    // a result carries a read byte or a segment report, never both
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.read_valid) |-> (!o_result.ack_now && !o_result.reject_now))
        else $error("read and report in one result");

    // nothing is emitted before the clearing pass is over
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_pop && !emit)
        else $error("activity during clearing pass");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the receive reassembly buffer: a directed table of
// segment and read items, then random segment streams with reads, all checked
// field by field against typed-in results or a behavioral ring-buffer predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import rrb_pkg::*;

    localparam int DEPTH = 4096;

    // one input item
    typedef struct {
        logic        kind;
        logic [31:0] seg_start;
        logic [15:0] seg_length;
        logic [15:0] byte_offset;
        logic [7:0]  data_byte;
        logic        last_seg;
    } t_in;

    // one result item
    typedef struct {
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        ack_now;
        logic        reject_now;
        logic [31:0] ack_seq;
        logic [15:0] echo_len;
        logic [12:0] available;
    } t_out;

    // directed row: item plus optional typed-in result
    typedef struct {
        t_in  item;
        bit   has_fixed;
        t_out fixed;
    } t_row;

    logic        i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic        i_kind = 0, i_last_of_segment = 0;
    logic [31:0] i_seg_start = 0;
    logic [15:0] i_seg_length = 0, i_byte_offset = 0;
    logic [7:0]  i_data_byte = 0;
    logic        o_stall, o_valid, o_read_valid, o_ack_now, o_reject_now;
    logic [7:0]  o_read_byte;
    logic [31:0] o_ack_seq;
    logic [15:0] o_echo_len;
    logic [AVAIL_W-1:0] o_available;

    receive_reassembly_buffer #(.DEPTH(DEPTH)) dut (.*);

    // predictor state
    logic [7:0]  ring_bytes [DEPTH];
    bit          ring_marks [DEPTH];
    logic [$clog2(DEPTH)-1:0] head_slot;
    logic [31:0] head_seq;

    t_out pending_results[$];
    int   n_errors = 0, n_results = 0, n_acks = 0, n_rejects = 0, n_reads = 0;
    bit   quiet_rx = 0, hold_rx = 0, in_done = 0;

    function automatic logic [12:0] contiguous_run();
        int n = 0;
        while (n < DEPTH && ring_marks[(head_slot + n) % DEPTH]) n++;
        return n[12:0];
    endfunction

    // compute the result of one accepted item and update the ring
    function automatic t_out reassemble(t_in it);
        t_out r = '{default: '0};
        logic [31:0] seg_dist;
        bit ok;
        int slot;
        if (it.kind == KIND_SEG) begin
            seg_dist = it.seg_start - head_seq;
            ok = !seg_dist[31] && seg_dist < DEPTH && (64'(seg_dist) + it.seg_length) < DEPTH;
            if (ok && it.byte_offset < it.seg_length) begin
                slot = (int'(head_slot) + int'(seg_dist) + int'(it.byte_offset)) % DEPTH;
                ring_bytes[slot] = it.data_byte;
                ring_marks[slot] = 1;
            end
            if (it.last_seg) begin
                r.ack_now = ok;
                r.reject_now = !ok;
                r.ack_seq = it.seg_start;
                r.echo_len = it.seg_length;
            end
        end else if (ring_marks[head_slot]) begin
            r.read_valid = 1;
            r.read_byte = ring_bytes[head_slot];
            ring_marks[head_slot] = 0;
            head_slot++;
            head_seq++;
        end
        r.available = contiguous_run();
        return r;
    endfunction

    function automatic t_in seg_item(logic [31:0] s, logic [15:0] l, logic [15:0] o,
                                     logic [7:0] b, logic lst);
        t_in t;
        t.kind = KIND_SEG; t.seg_start = s; t.seg_length = l;
        t.byte_offset = o; t.data_byte = b; t.last_seg = lst;
        return t;
    endfunction

    function automatic t_in read_item(logic lst);
        t_in t;
        t.kind = KIND_READ; t.seg_start = $urandom; t.seg_length = 16'($urandom);
        t.byte_offset = 16'($urandom); t.data_byte = 8'($urandom); t.last_seg = lst;
        return t;
    endfunction

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // hard limit
    initial begin
        #(8 * 2_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // receiver stall: random, with a quiet stretch and one long hold-off
    always @(negedge i_clk) begin
        i_stall <= hold_rx || (!quiet_rx && $urandom_range(99) < 14);
    end

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with no expectation");
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_read_valid !== e.read_valid) begin
                    $error("read_valid exp %0h got %0h", e.read_valid, o_read_valid);
                    n_errors++;
                end
                if (o_read_byte !== e.read_byte) begin
                    $error("read_byte exp %0h got %0h", e.read_byte, o_read_byte);
                    n_errors++;
                end
                if (o_ack_now !== e.ack_now) begin
                    $error("ack_now exp %0h got %0h", e.ack_now, o_ack_now);
                    n_errors++;
                end
                if (o_reject_now !== e.reject_now) begin
                    $error("reject_now exp %0h got %0h", e.reject_now, o_reject_now);
                    n_errors++;
                end
                if (o_ack_seq !== e.ack_seq) begin
                    $error("ack_seq exp %0h got %0h", e.ack_seq, o_ack_seq);
                    n_errors++;
                end
                if (o_echo_len !== e.echo_len) begin
                    $error("echo_len exp %0h got %0h", e.echo_len, o_echo_len);
                    n_errors++;
                end
                if (o_available !== e.available) begin
                    $error("available exp %0h got %0h", e.available, o_available);
                    n_errors++;
                end
                n_acks += e.ack_now;
                n_rejects += e.reject_now;
                n_reads += e.read_valid;
            end
        end
    end

    // send one item; waits for acceptance, idles at random beforehand
    task automatic send_item(t_in it, bit quiet);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 14) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_kind <= it.kind; i_seg_start <= it.seg_start; i_seg_length <= it.seg_length;
        i_byte_offset <= it.byte_offset; i_data_byte <= it.data_byte;
        i_last_of_segment <= it.last_seg;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(reassemble(it));
    endtask

    // send an item whose expectation was already queued
    task automatic send_fixed(t_in it);
        @(negedge i_clk);
        i_valid <= 1;
        i_kind <= it.kind; i_seg_start <= it.seg_start; i_seg_length <= it.seg_length;
        i_byte_offset <= it.byte_offset; i_data_byte <= it.data_byte;
        i_last_of_segment <= it.last_seg;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // drop valid once the sender has nothing more to offer
    task automatic idle_input();
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    // send a whole segment at a head-relative offset, with some interleaved reads
    task automatic send_segment(int rel, int len, bit shuffle, bit quiet);
        logic [31:0] s;
        int order[$];
        s = head_seq + rel;
        for (int k = 0; k < len; k++) order.push_back(k);
        if (shuffle) order.shuffle();
        if (len == 0) order.push_back(0);
        foreach (order[k]) begin
            if ($urandom_range(99) < 10) send_item(read_item($urandom_range(1)), quiet);
            send_item(seg_item(s, 16'(len), 16'(order[k]), 8'($urandom),
                               k == order.size() - 1), quiet);
        end
    endtask

    t_row rows[$];
    int   n_items;

    initial begin
        t_out fx;
        int got;
        for (int k = 0; k < DEPTH; k++) ring_marks[k] = 0;
        head_slot = 0;
        head_seq = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;

        // directed table: read of empty head, extremes, rejects, beyond-segment byte
        fx = '{default: '0};
        rows.push_back('{read_item(1), 1, fx});
        fx = '{default: '0}; fx.ack_now = 1; fx.echo_len = 1; fx.available = 1;
        rows.push_back('{seg_item(0, 1, 0, 8'hFF, 1), 1, fx});
        fx = '{default: '0}; fx.read_valid = 1; fx.read_byte = 8'hFF;
        rows.push_back('{read_item(0), 1, fx});
        fx = '{default: '0}; fx.reject_now = 1; fx.ack_seq = 32'hFFFF_FFFF;
        fx.echo_len = 16'hFFFF;
        rows.push_back('{seg_item(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 1), 1, fx});
        // widest segment that still fits the window
        fx = '{default: '0}; fx.ack_now = 1; fx.ack_seq = 1; fx.echo_len = 4095;
        fx.available = 1;
        rows.push_back('{seg_item(1, 4095, 0, 8'hAA, 1), 1, fx});
        fx = '{default: '0}; fx.reject_now = 1; fx.ack_seq = 4097; fx.available = 1;
        rows.push_back('{seg_item(4097, 0, 0, 8'h55, 1), 1, fx});
        rows.push_back('{seg_item(1, 4094, 4093, 8'h11, 1), 0, fx});
        rows.push_back('{seg_item(1, 4, 7, 8'h22, 0), 0, fx});
        rows.push_back('{seg_item(1, 4, 0, 8'h00, 0), 0, fx});
        rows.push_back('{seg_item(2, 2, 0, 8'h5A, 0), 0, fx});
        rows.push_back('{read_item(1), 0, fx});
        rows.push_back('{seg_item(1, 4, 2, 8'hA5, 1), 0, fx});
        rows.push_back('{seg_item(32'h8000_0001, 16'h8000, 16'h7FFF, 8'h0F, 1), 0, fx});
        rows.push_back('{read_item(0), 0, fx});
        rows.push_back('{read_item(1), 0, fx});
        rows.push_back('{read_item(0), 0, fx});
        foreach (rows[r]) begin
            if (rows[r].has_fixed) begin
                void'(reassemble(rows[r].item));
                pending_results.push_back(rows[r].fixed);
                send_fixed(rows[r].item);
            end else begin
                send_item(rows[r].item, 0);
            end
        end

        // random: mostly in-window segments, some out of window, plenty of reads
        n_items = 0;
        while (n_items < 2000) begin
            int pick, len, before_cnt;
            before_cnt = pending_results.size() + n_results;
            pick = $urandom_range(99);
            quiet_rx = (n_items > 600 && n_items < 800);
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 12);
            if (pick < 55) begin
                send_segment($urandom_range(0, 60), len, $urandom_range(1), quiet_rx);
            end else if (pick < 63) begin
                case ($urandom_range(3))
                    0: send_item(seg_item($urandom, 16'($urandom), 16'($urandom),
                                          8'($urandom), 1), 0);
                    1: send_item(seg_item(head_seq - $urandom_range(1, 50), 4, 0,
                                          8'($urandom), 1), 0);
                    2: send_item(seg_item(head_seq + $urandom_range(0, 4095),
                                          16'($urandom_range(4090, 65535)),
                                          16'($urandom), 8'($urandom), 1), 0);
                    default: send_segment(DEPTH - 1 - len, len, 0, 0);
                endcase
            end else begin
                repeat ($urandom_range(1, 20)) send_item(read_item($urandom_range(1)), quiet_rx);
            end
            n_items += pending_results.size() + n_results - before_cnt;
        end
        idle_input();

        // long receiver hold-off while the sender keeps offering items
        fork
            begin
                hold_rx = 1;
                repeat (300) @(negedge i_clk);
                hold_rx = 0;
            end
            repeat (40) send_item(read_item(0), 1);
        join
        idle_input();

        // drain phase
        got = 0;
        while (pending_results.size() != 0 && got < 200000) begin
            @(posedge i_clk);
            got++;
        end
        repeat (50) @(posedge i_clk);
        $display("Covered %0d results: %0d acks, %0d rejects, %0d bytes read back.",
                 n_results, n_acks, n_rejects, n_reads);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
